### design/cpr_pkg.sv
// Shared types, codes and helpers for the collision push-out resolver.
// Used by the controller, datapath, iterative unit and top level.
package cpr_pkg;

    localparam int DIV_STEPS  = 48;
    localparam int SQRT_STEPS = 32;

    localparam logic [1:0] COMP_LAST = 2'd2;

    localparam logic [1:0] REG_OWN_RATE    = 2'd0;
    localparam logic [1:0] REG_OWN_PUSHES  = 2'd1;
    localparam logic [1:0] REG_OWN_INERTIA = 2'd2;
    localparam logic [1:0] REG_MIN_LENGTH  = 2'd3;

    localparam logic [15:0] RST_OWN_RATE    = 16'd256;
    localparam logic        RST_OWN_PUSHES  = 1'b1;
    localparam logic        RST_OWN_INERTIA = 1'b0;
    localparam logic [15:0] RST_MIN_LENGTH  = 16'd1;

    localparam logic signed [39:0] SAT_MAX = 40'sh007FFFFFFF;
    localparam logic signed [39:0] SAT_MIN = 40'shFF80000000;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_SIDE, S_MULR, S_DIVR, S_DIVW, S_SQ, S_CMP,
        S_SQRT, S_SQW, S_DIVU, S_DUW, S_DOT, S_DCHK, S_CMUL, S_CUPD,
        S_SAVE, S_EMIT0, S_EMIT1
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_CAPTURE, OP_LOADVEL, OP_SIDE, OP_MULR, OP_DIVR, OP_STD,
        OP_SQ, OP_SQRT, OP_STL, OP_DIVU, OP_STU, OP_DOT, OP_CMUL, OP_CUPD,
        OP_SAVE, OP_EMIT0, OP_EMIT1
    } dp_op_t;

    typedef enum logic {UM_DIV, UM_SQRT} unit_mode_t;

    typedef struct packed {
        logic [15:0] own_rate;
        logic        own_pushes;
        logic        own_has_inertia;
        logic [15:0] min_length;
    } cfg_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] k;
        logic       side;
    } cmd_t;

    typedef struct packed {
        logic func;
        logic sum_zero;
        logic long_enough;
        logic inertia;
        logic dot_le0;
        logic unit_done;
        logic m_free;
        logic res0_vld;
        logic res1_vld;
    } stat_t;

    typedef struct packed {
        logic        chg;
        logic [31:0] vz;
        logic [31:0] vy;
        logic [31:0] vx;
        logic [31:0] dz;
        logic [31:0] dy;
        logic [31:0] dx;
    } res_t;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [39:0] v);
        logic [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'h7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### design/cpr_divsqrt.sv
// Shared iterative unit: restoring divider (one quotient bit per cycle)
// and integer square root (one root bit per cycle). Depends on cpr_pkg.
module cpr_divsqrt (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  cpr_pkg::unit_mode_t mode,
    input  logic [63:0]         arg,
    input  logic [33:0]         den,
    output logic                done,
    output logic [63:0]         result
);
    import cpr_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    unit_mode_t  mode_reg;
    logic [5:0]  cnt_reg;
    logic [33:0] rem_reg;
    logic [47:0] quo_reg;
    logic [33:0] den_reg;
    logic [63:0] rad_reg;
    logic [63:0] root_reg;
    logic [63:0] bit_reg;

    logic [34:0] trial;
    logic [34:0] diff;
    logic        ge;
    logic [63:0] sqsum;
    logic        sq_ge;
    logic [5:0]  last_cnt;

    assign trial    = {rem_reg, quo_reg[47]};
    assign ge       = trial >= {1'b0, den_reg};
    assign diff     = trial - {1'b0, den_reg};
    assign sqsum    = root_reg + bit_reg;
    assign sq_ge    = rad_reg >= sqsum;
    assign last_cnt = (mode_reg == UM_DIV) ? 6'(DIV_STEPS - 1) : 6'(SQRT_STEPS - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == last_cnt) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mode_reg <= mode;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= arg[47:0];
            den_reg  <= den;
            rad_reg  <= arg;
            root_reg <= '0;
            bit_reg  <= 64'h4000_0000_0000_0000;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 6'd1;
            if (mode_reg == UM_DIV) begin
                rem_reg <= ge ? diff[33:0] : trial[33:0];
                quo_reg <= {quo_reg[46:0], ge};
            end else begin
                if (sq_ge) begin
                    rad_reg  <= rad_reg - sqsum;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end else begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
        end
    end

    assign done   = done_reg;
    assign result = (mode_reg == UM_DIV) ? {16'd0, quo_reg} : root_reg;

endmodule

### design/cpr_datapath.sv
// Datapath: item capture, rate split, length test, direction, velocity
// correction, result buffers and output register. Depends on cpr_pkg, cpr_divsqrt.
module cpr_datapath (
    input  logic            aclk,
    input  logic            aresetn,
    input  cpr_pkg::cfg_t   cfg,
    input  cpr_pkg::cmd_t   cmd,
    output cpr_pkg::stat_t  stat,
    input  logic [215:0]    s_tdata,
    input  logic [0:0]      s_tuser,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [199:0]    m_tdata,
    output logic [0:0]      m_tuser,
    output logic            m_tlast
);
    import cpr_pkg::*;

    logic               func_reg;
    logic [31:0]        vec_reg  [3];
    logic               pp_reg;
    logic [15:0]        prate_reg;
    logic               pin_reg;
    logic [31:0]        pvel_reg [3];
    logic [31:0]        ownv_reg [3];
    logic [31:0]        wvel_reg [3];
    logic [31:0]        d_reg    [3];
    logic signed [17:0] u_reg    [3];
    logic [47:0]        prod_reg;
    logic [63:0]        dd_reg;
    logic [32:0]        len_reg;
    logic signed [51:0] acc_reg;
    logic signed [53:0] cprod_reg;
    logic               chg_reg;
    res_t               res0_reg;
    res_t               res1_reg;
    logic               res0_vld_reg;
    logic               res1_vld_reg;
    logic               m_valid_reg;
    res_t               m_res_reg;
    logic               m_target_reg;
    logic               m_last_reg;

    logic [15:0]        rate_s;
    logic [15:0]        rate_p;
    logic [16:0]        rate_sum;
    logic [15:0]        rate_side;
    logic [31:0]        vmag;
    logic [31:0]        dmag;
    logic [31:0]        q32;
    logic signed [39:0] qsig;
    logic [31:0]        d_new;
    logic [63:0]        sq;
    logic [31:0]        eps2;
    logic signed [17:0] u_new;
    logic signed [49:0] dotp;
    logic signed [35:0] dot;
    logic signed [53:0] cprod_new;
    logic signed [39:0] nv;
    logic               unit_start;
    unit_mode_t         unit_mode;
    logic [63:0]        unit_arg;
    logic [33:0]        unit_den;
    logic               unit_done;
    logic [63:0]        unit_res;
    logic               m_free;

    assign rate_s    = pp_reg ? cfg.own_rate : 16'd0;
    assign rate_p    = cfg.own_pushes ? prate_reg : 16'd0;
    assign rate_sum  = {1'b0, rate_s} + {1'b0, rate_p};
    assign rate_side = cmd.side ? rate_p : rate_s;

    assign vmag = mag32(vec_reg[cmd.k]);
    assign dmag = mag32(d_reg[cmd.k]);

    // partner share is negated, so flip the sign for that side
    assign q32   = unit_res[31:0];
    assign qsig  = (vec_reg[cmd.k][31] ^ cmd.side) ? -$signed({8'd0, q32})
                                                   : $signed({8'd0, q32});
    assign d_new = sat32(qsig);

    assign sq   = {32'd0, dmag} * {32'd0, dmag};
    assign eps2 = {16'd0, cfg.min_length} * {16'd0, cfg.min_length};

    assign u_new = d_reg[cmd.k][31] ? -$signed({1'b0, unit_res[16:0]})
                                    : $signed({1'b0, unit_res[16:0]});

    assign dotp      = 50'($signed(wvel_reg[cmd.k])) * 50'(u_reg[cmd.k]);
    assign dot       = acc_reg[51:16];
    assign cprod_new = 54'(u_reg[cmd.k]) * 54'(dot);
    assign nv        = 40'($signed(wvel_reg[cmd.k])) - 40'($signed(cprod_reg[53:16]));

    assign unit_start = (cmd.op == OP_DIVR) || (cmd.op == OP_DIVU) || (cmd.op == OP_SQRT);
    assign unit_mode  = (cmd.op == OP_SQRT) ? UM_SQRT : UM_DIV;

    always_comb begin
        case (cmd.op)
            OP_DIVR: begin
                unit_arg = {16'd0, prod_reg};
                unit_den = {17'd0, rate_sum};
            end
            OP_DIVU: begin
                unit_arg = {16'd0, dmag, 16'd0};
                unit_den = {1'b0, len_reg};
            end
            OP_SQRT: begin
                unit_arg = dd_reg;
                unit_den = {17'd0, rate_sum};
            end
            default: begin
                unit_arg = {16'd0, prod_reg};
                unit_den = {17'd0, rate_sum};
            end
        endcase
    end

    cpr_divsqrt u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (unit_start),
        .mode    (unit_mode),
        .arg     (unit_arg),
        .den     (unit_den),
        .done    (unit_done),
        .result  (unit_res)
    );

    assign m_free = !m_valid_reg || m_tready;

    always_comb begin
        stat.func        = func_reg;
        stat.sum_zero    = (rate_sum == 17'd0);
        stat.long_enough = dd_reg > {32'd0, eps2};
        stat.inertia     = cmd.side ? pin_reg : cfg.own_has_inertia;
        stat.dot_le0     = (dot <= 36'sd0);
        stat.unit_done   = unit_done;
        stat.m_free      = m_free;
        stat.res0_vld    = res0_vld_reg;
        stat.res1_vld    = res1_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            res0_vld_reg <= 1'b0;
            res1_vld_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                ownv_reg[i] <= '0;
            end
        end else begin
            if (cmd.op == OP_EMIT0 || cmd.op == OP_EMIT1) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_CAPTURE: begin
                    res0_vld_reg <= 1'b0;
                    res1_vld_reg <= 1'b0;
                end
                OP_LOADVEL: begin
                    for (int i = 0; i < 3; i++) begin
                        ownv_reg[i] <= vec_reg[i];
                    end
                end
                OP_SAVE: begin
                    if (cmd.side) begin
                        res1_vld_reg <= 1'b1;
                    end else begin
                        res0_vld_reg <= 1'b1;
                        for (int i = 0; i < 3; i++) begin
                            ownv_reg[i] <= wvel_reg[i];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_CAPTURE: begin
                func_reg    <= s_tuser[0];
                vec_reg[0]  <= s_tdata[31:0];
                vec_reg[1]  <= s_tdata[63:32];
                vec_reg[2]  <= s_tdata[95:64];
                pp_reg      <= s_tdata[96];
                prate_reg   <= s_tdata[112:97];
                pin_reg     <= s_tdata[113];
                pvel_reg[0] <= s_tdata[145:114];
                pvel_reg[1] <= s_tdata[177:146];
                pvel_reg[2] <= s_tdata[209:178];
            end
            OP_SIDE: begin
                for (int i = 0; i < 3; i++) begin
                    wvel_reg[i] <= cmd.side ? pvel_reg[i] : ownv_reg[i];
                end
                dd_reg  <= '0;
                acc_reg <= '0;
                chg_reg <= 1'b0;
            end
            OP_MULR: prod_reg <= vmag * rate_side;
            OP_STD:  d_reg[cmd.k] <= d_new;
            OP_SQ:   dd_reg <= dd_reg + sq;
            OP_STL:  len_reg <= unit_res[32:0];
            OP_STU:  u_reg[cmd.k] <= u_new;
            OP_DOT:  acc_reg <= acc_reg + 52'(dotp);
            OP_CMUL: cprod_reg <= cprod_new;
            OP_CUPD: begin
                wvel_reg[cmd.k] <= sat32(nv);
                chg_reg         <= 1'b1;
            end
            OP_SAVE: begin
                if (cmd.side) begin
                    res1_reg <= '{chg: chg_reg, vz: wvel_reg[2], vy: wvel_reg[1],
                                  vx: wvel_reg[0], dz: d_reg[2], dy: d_reg[1],
                                  dx: d_reg[0]};
                end else begin
                    res0_reg <= '{chg: chg_reg, vz: wvel_reg[2], vy: wvel_reg[1],
                                  vx: wvel_reg[0], dz: d_reg[2], dy: d_reg[1],
                                  dx: d_reg[0]};
                end
            end
            OP_EMIT0: begin
                m_res_reg    <= res0_reg;
                m_target_reg <= 1'b0;
                m_last_reg   <= !res1_vld_reg;
            end
            OP_EMIT1: begin
                m_res_reg    <= res1_reg;
                m_target_reg <= 1'b1;
                m_last_reg   <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_res_reg};
    assign m_tuser  = m_target_reg;
    assign m_tlast  = m_last_reg;

endmodule

### design/cpr_ctrl.sv
// Controller: sequences one item at a time through the datapath.
// Depends on cpr_pkg.
module cpr_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  cpr_pkg::stat_t stat,
    output cpr_pkg::cmd_t  cmd
);
    import cpr_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] k_reg, k_next;
    logic       side_reg, side_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            side_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            side_reg  <= side_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        side_next  = side_reg;
        case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_DECODE;
            S_DECODE: begin
                if (!stat.func || stat.sum_zero) begin
                    state_next = S_IDLE;
                end else begin
                    side_next  = 1'b0;
                    state_next = S_SIDE;
                end
            end
            S_SIDE: begin
                k_next     = '0;
                state_next = S_MULR;
            end
            S_MULR: state_next = S_DIVR;
            S_DIVR: state_next = S_DIVW;
            S_DIVW: begin
                if (stat.unit_done) begin
                    if (k_reg == COMP_LAST) begin
                        k_next     = '0;
                        state_next = S_SQ;
                    end else begin
                        k_next     = k_reg + 2'd1;
                        state_next = S_MULR;
                    end
                end
            end
            S_SQ: begin
                if (k_reg == COMP_LAST) begin
                    k_next     = '0;
                    state_next = S_CMP;
                end else begin
                    k_next = k_reg + 2'd1;
                end
            end
            S_CMP: begin
                if (!stat.long_enough) begin
                    if (!side_reg) begin
                        side_next  = 1'b1;
                        state_next = S_SIDE;
                    end else begin
                        state_next = S_EMIT0;
                    end
                end else if (!stat.inertia) begin
                    state_next = S_SAVE;
                end else begin
                    state_next = S_SQRT;
                end
            end
            S_SQRT: state_next = S_SQW;
            S_SQW: begin
                if (stat.unit_done) begin
                    k_next     = '0;
                    state_next = S_DIVU;
                end
            end
            S_DIVU: state_next = S_DUW;
            S_DUW: begin
                if (stat.unit_done) begin
                    if (k_reg == COMP_LAST) begin
                        k_next     = '0;
                        state_next = S_DOT;
                    end else begin
                        k_next     = k_reg + 2'd1;
                        state_next = S_DIVU;
                    end
                end
            end
            S_DOT: begin
                if (k_reg == COMP_LAST) begin
                    k_next     = '0;
                    state_next = S_DCHK;
                end else begin
                    k_next = k_reg + 2'd1;
                end
            end
            S_DCHK: state_next = stat.dot_le0 ? S_CMUL : S_SAVE;
            S_CMUL: state_next = S_CUPD;
            S_CUPD: begin
                if (k_reg == COMP_LAST) begin
                    k_next     = '0;
                    state_next = S_SAVE;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_CMUL;
                end
            end
            S_SAVE: begin
                if (!side_reg) begin
                    side_next  = 1'b1;
                    state_next = S_SIDE;
                end else begin
                    state_next = S_EMIT0;
                end
            end
            S_EMIT0: if (!stat.res0_vld || stat.m_free) state_next = S_EMIT1;
            S_EMIT1: if (!stat.res1_vld || stat.m_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd.k    = k_reg;
        cmd.side = side_reg;
        cmd.op   = OP_NONE;
        case (state_reg)
            S_IDLE:   if (s_tvalid) cmd.op = OP_CAPTURE;
            S_DECODE: if (!stat.func) cmd.op = OP_LOADVEL;
            S_SIDE:   cmd.op = OP_SIDE;
            S_MULR:   cmd.op = OP_MULR;
            S_DIVR:   cmd.op = OP_DIVR;
            S_DIVW:   if (stat.unit_done) cmd.op = OP_STD;
            S_SQ:     cmd.op = OP_SQ;
            S_SQRT:   cmd.op = OP_SQRT;
            S_SQW:    if (stat.unit_done) cmd.op = OP_STL;
            S_DIVU:   cmd.op = OP_DIVU;
            S_DUW:    if (stat.unit_done) cmd.op = OP_STU;
            S_DOT:    cmd.op = OP_DOT;
            S_CMUL:   cmd.op = OP_CMUL;
            S_CUPD:   cmd.op = OP_CUPD;
            S_SAVE:   cmd.op = OP_SAVE;
            S_EMIT0:  if (stat.res0_vld && stat.m_free) cmd.op = OP_EMIT0;
            S_EMIT1:  if (stat.res1_vld && stat.m_free) cmd.op = OP_EMIT1;
            default:  cmd.op = OP_NONE;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

### design/collision_pushout_resolver.sv
// Top level of the collision push-out resolver: config registers, controller,
// datapath. Depends on cpr_pkg, cpr_ctrl, cpr_datapath.
//
//   channel  | dir | handshake          | payload
//   s_*      | in  | s_tvalid/s_tready  | s_tdata 216b, s_tuser 1b
//   m_*      | out | m_tvalid/m_tready  | m_tdata 200b, m_tuser 1b, m_tlast
//   apb      | in  | psel/penable/pready| paddr 4b, pwdata/prdata 32b
//
// One item at a time. A load passes through capture and decode. A hit runs
// the rate split for each side and, when that side has inertia and its share
// is long enough, the square root and direction divisions as well; the
// shared 48-step divider sets most of the run time.
// Reset is synchronous and clears control state and the stored own velocity.
// A stalled m_tready holds the output register; results wait in it.
module collision_pushout_resolver (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vec_x, vec_y, vec_z, partner_pushes, partner_rate, partner_has_inertia,
    // partner_vel_x, partner_vel_y, partner_vel_z
    input  logic [215:0] s_tdata,
    // func
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // disp_x, disp_y, disp_z, vel_out_x, vel_out_y, vel_out_z, vel_changed
    output logic [199:0] m_tdata,
    // target
    output logic [0:0]   m_tuser,
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import cpr_pkg::*;

    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t stat;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.own_rate        <= RST_OWN_RATE;
            cfg_reg.own_pushes      <= RST_OWN_PUSHES;
            cfg_reg.own_has_inertia <= RST_OWN_INERTIA;
            cfg_reg.min_length      <= RST_MIN_LENGTH;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_OWN_RATE:    cfg_reg.own_rate        <= pwdata[15:0];
                REG_OWN_PUSHES:  cfg_reg.own_pushes      <= pwdata[0];
                REG_OWN_INERTIA: cfg_reg.own_has_inertia <= pwdata[0];
                REG_MIN_LENGTH:  cfg_reg.min_length      <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_OWN_RATE:    prdata = {16'd0, cfg_reg.own_rate};
            REG_OWN_PUSHES:  prdata = {31'd0, cfg_reg.own_pushes};
            REG_OWN_INERTIA: prdata = {31'd0, cfg_reg.own_has_inertia};
            REG_MIN_LENGTH:  prdata = {16'd0, cfg_reg.min_length};
            default:         prdata = '0;
        endcase
    end

    cpr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cpr_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### design/cpr_checker.sv
// Port-level checks for the collision push-out resolver, bound to the top.
// Depends on collision_pushout_resolver port names only.
module cpr_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [215:0] s_tdata,
    input logic [0:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [199:0] m_tdata,
    input logic [0:0]   m_tuser,
    input logic         m_tlast,
    input logic         psel,
    input logic         penable,
    input logic         pwrite,
    input logic [3:0]   paddr,
    input logic [31:0]  pwdata,
    input logic [31:0]  prdata,
    input logic         pready
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("result changed while stalled");

    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // one item at a time: no back-to-back input transfers
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while busy");

    // a partner result always closes its hit
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("partner result without tlast");

endmodule

bind collision_pushout_resolver cpr_checker u_cpr_checker (.*);
